// File: rtl/core/wzot_pkg.sv
`timescale 1ns / 1ps

package wzot_pkg;

    // Command codes
    localparam logic [2:0] OP_CREATE = 3'd0;
    localparam logic [2:0] OP_MOVE   = 3'd1;
    localparam logic [2:0] OP_RAISE  = 3'd2;
    localparam logic [2:0] OP_HIT    = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    // Result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_BAD_SIZE = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;
    localparam logic [1:0] STAT_NOT_OPEN = 2'd3;

    // Background color of a new window: base plus slot times step
    localparam logic [23:0] BG_BASE = 24'h203050;
    localparam logic [23:0] BG_STEP = 24'h001010;

    // Input beat
    typedef struct packed {
        logic        [2:0]  operation;
        logic        [3:0]  slot_index;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] size_w;
        logic signed [15:0] size_h;
    } t_cmd;

    // Output beat
    typedef struct packed {
        logic        [1:0]  status;
        logic        [3:0]  slot_out;
        logic signed [15:0] rect_x;
        logic signed [15:0] rect_y;
        logic        [14:0] rect_w;
        logic        [14:0] rect_h;
        logic        [23:0] background;
    } t_result;

    // One word of the window table memory
    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic        [14:0] width;
        logic        [14:0] height;
        logic        [31:0] rank;
    } t_entry;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FREE,
        ST_MOD,
        ST_HIT,
        ST_HIT_END,
        ST_RESULT
    } t_state;

endpackage

// File: rtl/core/window_z_order_table_top.sv
`timescale 1ns / 1ps

// Channel  Direction  Beat                  Handshake
// command  in         i_data  (t_cmd)       i_valid / o_stall
// result   out        o_data  (t_result)    o_valid / i_stall
//
// One command at a time, one result beat per command.
// Create scans the open bits one slot a cycle.
// Hit test reads the table memory one slot a cycle.
// Move and raise do one memory read, then write back; read does the memory read only.
// Reset clears all open bits at once; the table memory itself needs no clear.
// A finished result waits in the output register while the next command runs.

module window_z_order_table_top #(
    parameter int SLOTS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  wzot_pkg::t_cmd       i_data,
    output logic                 o_stall,
    output logic                 o_valid,
    output wzot_pkg::t_result    o_data,
    input  logic                 i_stall
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    wzot_pkg::t_state  r_state, n_state;
    wzot_pkg::t_cmd    r_cmd, n_cmd;
    wzot_pkg::t_result r_res, n_res;
    wzot_pkg::t_result r_out, n_out;
    logic              r_out_valid, n_out_valid;
    logic [SLOTS-1:0]  r_open, n_open;
    logic [31:0]       r_next_rank, n_next_rank;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [23:0]       r_bg, n_bg;
    logic [31:0]       r_best_rank, n_best_rank;
    logic [IW-1:0]     r_best_slot, n_best_slot;
    logic              r_hit, n_hit;
    logic              r_pv, n_pv;
    logic [IW-1:0]     r_pi, n_pi;

    // Table memory
    wzot_pkg::t_entry  r_mem [SLOTS];
    wzot_pkg::t_entry  r_rd_data;
    logic              mem_we;
    logic [IW-1:0]     mem_wa;
    wzot_pkg::t_entry  mem_wd;
    logic              rd_en;
    logic [IW-1:0]     rd_addr;

    logic              size_ok;
    logic              idx_ok;
    logic              scan_done;
    logic [IW-1:0]     cnt_idx;
    logic              in_box;
    logic              hit_take;
    logic signed [16:0] right_edge;
    logic signed [16:0] bottom_edge;

    // Command checks on the incoming beat
    assign size_ok = (i_data.size_w > 16'sd0) && (i_data.size_h > 16'sd0);
    assign idx_ok  = ({28'd0, i_data.slot_index} < 32'(SLOTS))
                     && r_open[IW'(i_data.slot_index)];

    assign scan_done = (r_cnt == CW'(SLOTS));
    assign cnt_idx   = r_cnt[IW-1:0];

    // Containment of the point in the entry read last cycle, no overflow
    assign right_edge  = {r_rd_data.left[15], r_rd_data.left}
                         + $signed({2'b00, r_rd_data.width});
    assign bottom_edge = {r_rd_data.top[15], r_rd_data.top}
                         + $signed({2'b00, r_rd_data.height});
    assign in_box = (r_cmd.pos_x >= r_rd_data.left)
                    && ($signed({r_cmd.pos_x[15], r_cmd.pos_x}) < right_edge)
                    && (r_cmd.pos_y >= r_rd_data.top)
                    && ($signed({r_cmd.pos_y[15], r_cmd.pos_y}) < bottom_edge);
    // Ties go to the later slot
    assign hit_take = r_pv && in_box && (r_rd_data.rank >= r_best_rank);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wzot_pkg::ST_IDLE: begin
                if (i_valid) begin
                    case (i_data.operation) inside
                        wzot_pkg::OP_CREATE:
                            n_state = size_ok ? wzot_pkg::ST_FREE : wzot_pkg::ST_RESULT;
                        wzot_pkg::OP_MOVE, wzot_pkg::OP_RAISE, wzot_pkg::OP_READ:
                            n_state = idx_ok ? wzot_pkg::ST_MOD : wzot_pkg::ST_RESULT;
                        wzot_pkg::OP_HIT:
                            n_state = wzot_pkg::ST_HIT;
                        default:
                            n_state = wzot_pkg::ST_RESULT;
                    endcase
                end
            end
            wzot_pkg::ST_FREE: begin
                if (scan_done || !r_open[cnt_idx]) begin
                    n_state = wzot_pkg::ST_RESULT;
                end
            end
            wzot_pkg::ST_MOD: begin
                n_state = wzot_pkg::ST_RESULT;
            end
            wzot_pkg::ST_HIT: begin
                if (scan_done) begin
                    n_state = wzot_pkg::ST_HIT_END;
                end
            end
            wzot_pkg::ST_HIT_END: begin
                n_state = wzot_pkg::ST_RESULT;
            end
            wzot_pkg::ST_RESULT: begin
                if (!r_out_valid || !i_stall) begin
                    n_state = wzot_pkg::ST_IDLE;
                end
            end
            default: n_state = wzot_pkg::ST_IDLE;
        endcase
    end

    // Datapath and memory controls per state
    always_comb begin
        n_cmd       = r_cmd;
        n_res       = r_res;
        n_open      = r_open;
        n_next_rank = r_next_rank;
        n_cnt       = r_cnt;
        n_bg        = r_bg;
        n_best_rank = r_best_rank;
        n_best_slot = r_best_slot;
        n_hit       = r_hit;
        n_pv        = 1'b0;
        n_pi        = r_pi;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_stall;
        mem_we      = 1'b0;
        mem_wa      = '0;
        mem_wd      = '0;
        rd_en       = 1'b0;
        rd_addr     = '0;

        unique case (r_state)
            wzot_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_cmd       = i_data;
                    n_res       = '0;
                    n_cnt       = '0;
                    n_bg        = wzot_pkg::BG_BASE;
                    n_best_rank = '0;
                    n_best_slot = '0;
                    n_hit       = 1'b0;
                    case (i_data.operation) inside
                        wzot_pkg::OP_CREATE: begin
                            if (!size_ok) begin
                                n_res.status = wzot_pkg::STAT_BAD_SIZE;
                            end
                        end
                        wzot_pkg::OP_MOVE, wzot_pkg::OP_RAISE, wzot_pkg::OP_READ: begin
                            if (idx_ok) begin
                                rd_en   = 1'b1;
                                rd_addr = IW'(i_data.slot_index);
                            end else begin
                                n_res.status = wzot_pkg::STAT_NOT_OPEN;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // Lowest free slot, one per cycle
            wzot_pkg::ST_FREE: begin
                if (scan_done) begin
                    n_res.status = wzot_pkg::STAT_FULL;
                end else if (!r_open[cnt_idx]) begin
                    mem_we              = 1'b1;
                    mem_wa              = cnt_idx;
                    mem_wd.left         = r_cmd.pos_x;
                    mem_wd.top          = r_cmd.pos_y;
                    mem_wd.width        = r_cmd.size_w[14:0];
                    mem_wd.height       = r_cmd.size_h[14:0];
                    mem_wd.rank         = r_next_rank;
                    n_open[cnt_idx]     = 1'b1;
                    n_next_rank         = r_next_rank + 32'd1;
                    n_res.slot_out      = 4'(r_cnt);
                    n_res.background    = r_bg;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                    n_bg  = r_bg + wzot_pkg::BG_STEP;
                end
            end

            // Entry read is back: modify and write, or return it
            wzot_pkg::ST_MOD: begin
                case (r_cmd.operation)
                    wzot_pkg::OP_MOVE: begin
                        mem_we      = 1'b1;
                        mem_wa      = IW'(r_cmd.slot_index);
                        mem_wd      = r_rd_data;
                        mem_wd.left = r_cmd.pos_x;
                        mem_wd.top  = r_cmd.pos_y;
                    end
                    wzot_pkg::OP_RAISE: begin
                        mem_we      = 1'b1;
                        mem_wa      = IW'(r_cmd.slot_index);
                        mem_wd      = r_rd_data;
                        mem_wd.rank = r_next_rank;
                        n_next_rank = r_next_rank + 32'd1;
                    end
                    wzot_pkg::OP_READ: begin
                        n_res.rect_x = r_rd_data.left;
                        n_res.rect_y = r_rd_data.top;
                        n_res.rect_w = r_rd_data.width;
                        n_res.rect_h = r_rd_data.height;
                    end
                    default: ;
                endcase
            end

            // Read slot cnt, judge the slot whose read data is now registered
            wzot_pkg::ST_HIT: begin
                if (!scan_done) begin
                    rd_en   = 1'b1;
                    rd_addr = cnt_idx;
                    n_pv    = r_open[cnt_idx];
                    n_pi    = cnt_idx;
                    n_cnt   = r_cnt + CW'(1);
                end
                if (hit_take) begin
                    n_best_rank = r_rd_data.rank;
                    n_best_slot = r_pi;
                    n_hit       = 1'b1;
                end
            end

            wzot_pkg::ST_HIT_END: begin
                if (r_hit) begin
                    n_res.slot_out = 4'(r_best_slot);
                end else begin
                    n_res.status = wzot_pkg::STAT_NOT_OPEN;
                end
            end

            // Hand the result to the output register once it is free
            wzot_pkg::ST_RESULT: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                end
            end

            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wzot_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_open      <= '0;
            r_next_rank <= 32'd1;
            r_pv        <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_open      <= n_open;
            r_next_rank <= n_next_rank;
            r_pv        <= n_pv;
            r_cnt       <= n_cnt;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_res       <= n_res;
        r_out       <= n_out;
        r_bg        <= n_bg;
        r_best_rank <= n_best_rank;
        r_best_slot <= n_best_slot;
        r_hit       <= n_hit;
        r_pi        <= n_pi;
    end

    // Table memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_stall = (r_state != wzot_pkg::ST_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(SLOTS))
        else $error("scan counter past slot count");

    a_hit_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wzot_pkg::ST_HIT_END && r_hit) |-> r_open[r_best_slot])
        else $error("hit test picked a closed slot");

    a_open_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_open) <= $past($countones(r_open)) + 1)
        else $error("more than one slot opened in a cycle");

    a_result_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wzot_pkg::ST_RESULT && (!r_out_valid || !i_stall)) |=> o_valid)
        else $error("finished result not shown");
`endif

endmodule
